@@ rtl/crs_pkg.sv @@
// crs_pkg: constants and widths shared by the colour ramp sampler.
// No dependencies.
package crs_pkg;

  localparam int STOP_COUNT     = 8;
  localparam int POS_FRAC_BITS  = 16;

  localparam int POS_W     = POS_FRAC_BITS + 1;
  localparam int STOP_W    = 33 + POS_W;
  localparam int VALID_BIT = STOP_W - 1;
  localparam int IDX_W     = (STOP_COUNT > 1) ? $clog2(STOP_COUNT) : 1;
  localparam int CNT_W     = $clog2(STOP_COUNT + 1);
  localparam int ADDR_W    = IDX_W + 3;
  localparam int DATA_W    = 64;
  localparam int NUM_W     = POS_W + 7;
  localparam int DIV_STAGES = 4;
  localparam int NSTG      = 3 + DIV_STAGES;

  localparam logic [POS_W-1:0]  POS_ONE = POS_W'(1) << POS_FRAC_BITS;
  localparam logic [31:0]       WHITE   = 32'hFFFF_FFFF;

  localparam logic [STOP_W-1:0] STOP0_RST =
    (STOP_W'(1) << VALID_BIT) | STOP_W'(32'hFFFF_FFFF);
  localparam logic [STOP_W-1:0] STOP1_RST =
    (STOP_W'(1) << VALID_BIT) | (STOP_W'(POS_ONE) << 32) | STOP_W'(32'hFFFF_FF00);

endpackage

@@ rtl/color_ramp_sampler_top.sv @@
// Colour ramp sampler: eight gradient stops in APB registers, RGBA lookup pipeline.
// Seven register stages: a word accepted into stage 1 passes through them in order to out_*.
// One word per clock sustained; the input stalls only when all seven stages hold a word
// and the output is stalled. Stage 1 ranks the position against the sorted stops,
// 2 picks the bracket, 3 multiplies, 4..7 run a restoring divider two quotient bits each.
// Synchronous active-low reset: stops return to opaque-to-clear white, pipeline empties.
// Depends on crs_pkg.
module color_ramp_sampler_top import crs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [POS_W-1:0]  in_ramp_position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // ---------------- configuration registers ----------------
  logic [STOP_W-1:0] stop_r [STOP_COUNT];
  logic [IDX_W-1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STOP_COUNT; i++)
        stop_r[i] <= (i == 0) ? STOP0_RST : ((i == 1) ? STOP1_RST : '0);
    end else if (psel && penable && pwrite && pready &&
                 (int'(cfg_idx) < STOP_COUNT)) begin
      stop_r[cfg_idx] <= pwdata[STOP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (int'(cfg_idx) < STOP_COUNT) prdata = DATA_W'(stop_r[cfg_idx]);
  end

  // ---------------- stop ranking (static between writes) ----------------
  // Stable rank: earlier register wins on equal offsets. Slot k of the sorted
  // table holds the stop of rank k; last_nxt marks slot n-1 one-hot.
  logic [POS_W-1:0] off     [STOP_COUNT];
  logic [31:0]      col     [STOP_COUNT];
  logic             vld     [STOP_COUNT];
  logic [IDX_W-1:0] rank    [STOP_COUNT];
  logic [POS_W-1:0] s_off_nxt [STOP_COUNT];
  logic [31:0]      s_col_nxt [STOP_COUNT];
  logic [STOP_COUNT-1:0] s_last_nxt;
  logic [CNT_W-1:0] s_n_nxt;

  logic [POS_W-1:0] s_off_r [STOP_COUNT];
  logic [31:0]      s_col_r [STOP_COUNT];
  logic [STOP_COUNT-1:0] s_last_r;
  logic [CNT_W-1:0] s_n_r;

  always_comb begin
    s_n_nxt = '0;
    for (int i = 0; i < STOP_COUNT; i++) begin
      vld[i] = stop_r[i][VALID_BIT];
      off[i] = (stop_r[i][32 +: POS_W] > POS_ONE) ? POS_ONE : stop_r[i][32 +: POS_W];
      col[i] = stop_r[i][31:0];
      if (vld[i]) s_n_nxt = s_n_nxt + 1'b1;
    end
    for (int i = 0; i < STOP_COUNT; i++) begin
      rank[i] = '0;
      for (int j = 0; j < STOP_COUNT; j++) begin
        if (vld[j] && (j != i) &&
            ((off[j] < off[i]) || ((off[j] == off[i]) && (j < i))))
          rank[i] = rank[i] + 1'b1;
      end
    end
    for (int k = 0; k < STOP_COUNT; k++) begin
      s_off_nxt[k]  = '0;
      s_col_nxt[k]  = '0;
      s_last_nxt[k] = (CNT_W'(k + 1) == s_n_nxt);
      for (int i = 0; i < STOP_COUNT; i++) begin
        if (vld[i] && (rank[i] == IDX_W'(k))) begin
          s_off_nxt[k] = off[i];
          s_col_nxt[k] = col[i];
        end
      end
    end
  end

  // reset image of the sorted table: opaque white at 0, clear white at 1.0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STOP_COUNT; k++) begin
        s_off_r[k] <= (k == 1) ? POS_ONE : '0;
        s_col_r[k] <= (k == 0) ? STOP0_RST[31:0] : ((k == 1) ? STOP1_RST[31:0] : '0);
      end
      s_last_r <= STOP_COUNT'(2);
      s_n_r    <= CNT_W'(2);
    end else begin
      s_off_r  <= s_off_nxt;
      s_col_r  <= s_col_nxt;
      s_last_r <= s_last_nxt;
      s_n_r    <= s_n_nxt;
    end
  end

  // ---------------- pipeline flow control ----------------
  // Each stage loads when it is empty or the one after it moves, so bubbles
  // close up and a waiting result does not block new words upstream.
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int s = NSTG - 2; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int s = 1; s < NSTG; s++)
        if (en[s]) v_r[s] <= v_r[s-1];
    end
  end

  // ---------------- stage 1: clamp and compare ----------------
  logic [POS_W-1:0]      x_nxt, x1_r;
  logic [STOP_COUNT-1:0] lt_nxt, lt1_r;

  always_comb begin
    x_nxt = (in_ramp_position > POS_ONE) ? POS_ONE : in_ramp_position;
    for (int k = 0; k < STOP_COUNT; k++)
      lt_nxt[k] = (CNT_W'(k) < s_n_r) && (s_off_r[k] < x_nxt);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1_r  <= x_nxt;
      lt1_r <= lt_nxt;
    end
  end

  // ---------------- stage 2: bracket select ----------------
  // lt is a prefix over the sorted slots: lower stop is its last set bit,
  // upper the first clear valid slot. Clamped cases pass one colour through
  // with range 1, dx 0, so the divider returns it unchanged. On the
  // last offset the last stop wins over ties, unless slot 0 ties too.
  logic [31:0]      c1_nxt, c2_nxt, c1_r, c2_r;
  logic [POS_W-1:0] rng_nxt, dx_nxt, rng2_r, dx2_r;

  always_comb begin
    logic [STOP_COUNT-1:0] sel_lo, sel_hi;
    logic [POS_W-1:0] o_lo, o_hi, o_last;
    logic [31:0]      col_lo, col_hi, col_last;
    o_lo = '0; o_hi = '0; o_last = '0; col_lo = '0; col_hi = '0; col_last = '0;
    for (int k = 0; k < STOP_COUNT; k++) begin
      sel_lo[k] = lt1_r[k] && ((k == STOP_COUNT - 1) ? 1'b1 : !lt1_r[(k + 1) % STOP_COUNT]);
      sel_hi[k] = !lt1_r[k] && (CNT_W'(k) < s_n_r) &&
                  ((k == 0) ? 1'b1 : lt1_r[(k + STOP_COUNT - 1) % STOP_COUNT]);
      if (sel_lo[k]) begin o_lo = o_lo | s_off_r[k]; col_lo = col_lo | s_col_r[k]; end
      if (sel_hi[k]) begin o_hi = o_hi | s_off_r[k]; col_hi = col_hi | s_col_r[k]; end
      if (s_last_r[k]) begin
        o_last   = o_last | s_off_r[k];
        col_last = col_last | s_col_r[k];
      end
    end
    c1_nxt  = WHITE;
    c2_nxt  = WHITE;
    rng_nxt = POS_W'(1);
    dx_nxt  = '0;
    if (s_n_r == '0) begin
      c1_nxt = WHITE;
    end else if (!lt1_r[0]) begin
      c1_nxt = s_col_r[0];
      c2_nxt = s_col_r[0];
    end else if (x1_r >= o_last) begin
      c1_nxt = col_last;
      c2_nxt = col_last;
    end else begin
      c1_nxt  = col_lo;
      c2_nxt  = col_hi;
      rng_nxt = o_hi - o_lo;
      dx_nxt  = x1_r - o_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c1_r   <= c1_nxt;
      c2_r   <= c2_nxt;
      rng2_r <= rng_nxt;
      dx2_r  <= dx_nxt;
    end
  end

  // ---------------- stage 3: weighted sum ----------------
  logic [NUM_W-1:0] num_nxt [4];
  logic [NUM_W-1:0] num3_r  [4];
  logic [POS_W-1:0] rng3_r;

  always_comb begin
    logic [POS_W-1:0] w1;
    logic [POS_W+7:0] p1, p2;
    w1 = rng2_r - dx2_r;
    for (int ch = 0; ch < 4; ch++) begin
      p1 = c1_r[24 - 8*ch +: 8] * w1;
      p2 = c2_r[24 - 8*ch +: 8] * dx2_r;
      num_nxt[ch] = NUM_W'(p1 + p2);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      num3_r <= num_nxt;
      rng3_r <= rng2_r;
    end
  end

  // ---------------- stages 4..7: restoring divide ----------------
  function automatic logic [NUM_W+7:0] div_pair(input logic [NUM_W-1:0] rem,
                                                 input logic [7:0] quo,
                                                 input logic [POS_W-1:0] dvs,
                                                 input int hb);
    logic [NUM_W-1:0] r;
    logic [NUM_W-1:0] d;
    logic [7:0]       q;
    r = rem;
    q = quo;
    for (int b = hb; b >= hb - 1; b--) begin
      d = NUM_W'(dvs) << b;
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return {r, q};
  endfunction

  logic [NUM_W-1:0] rem_r [DIV_STAGES][4];
  logic [7:0]       quo_r [DIV_STAGES][4];
  logic [POS_W-1:0] dvs_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    for (int d = 0; d < DIV_STAGES; d++) begin
      if (en[3 + d]) begin
        for (int ch = 0; ch < 4; ch++) begin
          if (d == 0)
            {rem_r[d][ch], quo_r[d][ch]} <= div_pair(num3_r[ch], 8'h00, rng3_r, 7);
          else
            {rem_r[d][ch], quo_r[d][ch]} <= div_pair(rem_r[(d + DIV_STAGES - 1) % DIV_STAGES][ch],
                                                     quo_r[(d + DIV_STAGES - 1) % DIV_STAGES][ch],
                                                     dvs_r[(d + DIV_STAGES - 1) % DIV_STAGES],
                                                     7 - 2*d);
        end
        dvs_r[d] <= (d == 0) ? rng3_r : dvs_r[(d + DIV_STAGES - 1) % DIV_STAGES];
      end
    end
  end

  assign out_red   = quo_r[DIV_STAGES-1][0];
  assign out_green = quo_r[DIV_STAGES-1][1];
  assign out_blue  = quo_r[DIV_STAGES-1][2];
  assign out_alpha = quo_r[DIV_STAGES-1][3];

endmodule

@@ tb/tb_color_ramp_sampler_top.sv @@
// Testbench for the colour ramp sampler: random and directed ramp positions
// against a local gradient predictor, with stop registers rewritten over APB.
// Depends on crs_pkg and color_ramp_sampler_top.
`timescale 1ns / 1ps
module tb_color_ramp_sampler_top import crs_pkg::*; ();

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  localparam int LATENCY    = 7;
  localparam int CYCLE_CAP  = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [POS_W-1:0] in_ramp_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  color_ramp_sampler_top u_top (.*);

  // local copy of the stop registers
  logic [STOP_W-1:0] stops [STOP_COUNT];

  logic [POS_W-1:0] pos_queue [$];
  rgba_t colour_queue [$];
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_req = 1'b0;     // toggled to ask for a long receiver hold-off
  bit hold_ack = 1'b0;
  int hold_cycles = 0;     // counted down by the hold process only
  int cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Gradient predictor: rank valid stops stably, then bracket and interpolate.
  function automatic rgba_t predict_colour(logic [POS_W-1:0] pos_in);
    logic [POS_W-1:0] offs [STOP_COUNT];
    logic [31:0] cols [STOP_COUNT];
    logic [POS_W-1:0] x, ko, rng, dx;
    logic [31:0] kc, c_lo, c_hi, res;
    logic [7:0] a, b;
    int n, j;
    n = 0;
    x = (pos_in > POS_ONE) ? POS_ONE : pos_in;
    for (int i = 0; i < STOP_COUNT; i++) begin
      if (stops[i][VALID_BIT]) begin
        ko = stops[i][32 +: POS_W];
        offs[n] = (ko > POS_ONE) ? POS_ONE : ko;
        cols[n] = stops[i][31:0];
        n++;
      end
    end
    if (n == 0) return rgba_t'(32'hFFFF_FFFF);
    for (int i = 1; i < n; i++) begin
      ko = offs[i];
      kc = cols[i];
      j = i;
      while (j > 0 && offs[j-1] > ko) begin
        offs[j] = offs[j-1];
        cols[j] = cols[j-1];
        j--;
      end
      offs[j] = ko;
      cols[j] = kc;
    end
    if (x <= offs[0]) return rgba_t'(cols[0]);
    if (x >= offs[n-1]) return rgba_t'(cols[n-1]);
    for (int i = 0; i + 1 < n; i++) begin
      if (x >= offs[i] && x <= offs[i+1]) begin
        rng = offs[i+1] - offs[i];
        dx = x - offs[i];
        c_lo = cols[i];
        c_hi = cols[i+1];
        for (int k = 0; k < 4; k++) begin
          a = c_lo[24-8*k +: 8];
          b = c_hi[24-8*k +: 8];
          if (rng == 0) res[24-8*k +: 8] = a;
          else res[24-8*k +: 8] = 8'((64'(a) * (rng - dx) + 64'(b) * dx) / rng);
        end
        return rgba_t'(res);
      end
    end
    return rgba_t'(cols[n-1]);
  endfunction

  // Append one position to the pending list.
  task automatic queue_pos(logic [POS_W-1:0] p);
    pos_queue = {pos_queue, p};
  endtask

  // Driver: offer the next pending position; hold it while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pos_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_ramp_position <= pos_queue[0];
          colour_queue = {colour_queue, predict_colour(pos_queue[0])};
          void'(pos_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
          in_ramp_position <= POS_W'($urandom);
        end
      end
    end
  end

  // Long receiver hold-off, started by a toggle of hold_req.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= 200;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Monitor: check each accepted word, then pick the next stall value.
  always @(posedge clk) begin
    rgba_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_red, out_green, out_blue, out_alpha};
        if (colour_queue.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          want = colour_queue.pop_front();
          if (got.red !== want.red)
            $display("%0t: red expected %h actual %h", $time, want.red, got.red);
          if (got.green !== want.green)
            $display("%0t: green expected %h actual %h", $time, want.green, got.green);
          if (got.blue !== want.blue)
            $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
          if (got.alpha !== want.alpha)
            $display("%0t: alpha expected %h actual %h", $time, want.alpha, got.alpha);
          if (got !== want) errors++;
        end
      end
      if (hold_cycles > 0)
        out_stall <= 1'b1;
      else
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Setup and access cycle of one APB write; mirrors the value locally.
  // The final wait lets the sorted stop table settle before new words.
  task automatic write_stop(int idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(8 * idx); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx < STOP_COUNT) stops[idx] = value[STOP_W-1:0];
    @(posedge clk);
  endtask

  // Wait for the pipeline to empty, then a margin of idle edges.
  task automatic drain();
    wait (pos_queue.size() == 0 && colour_queue.size() == 0);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_stop(bit want_valid);
    logic [DATA_W-1:0] w;
    logic [POS_W-1:0] o;
    w = {$urandom, $urandom};
    case ($urandom_range(5))
      0: o = '0;
      1: o = POS_ONE;
      2: o = POS_ONE + POS_W'($urandom_range(1, 65535));   // above one, saturates
      3: o = POS_W'($urandom_range(0, 8)) << 13;           // coarse, invites ties
      default: o = POS_W'($urandom_range(0, 65536));
    endcase
    w[32 +: POS_W] = o;
    w[VALID_BIT] = want_valid;
    return w;
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(9))
      0: return '0;
      1: return POS_ONE;
      2: return POS_W'($urandom);                          // anything, incl. above one
      3: return stops[$urandom_range(STOP_COUNT-1)][32 +: POS_W];  // on a stop
      default: return POS_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic random_setting();
    int nvalid;
    nvalid = $urandom_range(0, STOP_COUNT);
    for (int i = 0; i < STOP_COUNT; i++)
      write_stop(i, rand_stop($urandom_range(STOP_COUNT - 1) < nvalid));
  endtask

  initial begin
    stops[0] = STOP0_RST;
    stops[1] = STOP1_RST;
    for (int i = 2; i < STOP_COUNT; i++) stops[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset ramp, field extremes, position above one
    queue_pos(17'd0);
    queue_pos(17'd1);
    queue_pos(17'd32768);
    queue_pos(17'd65535);
    queue_pos(17'd65536);
    queue_pos(17'd65537);
    queue_pos(17'h1FFFF);
    drain();
    // no valid stop: opaque white
    for (int i = 0; i < STOP_COUNT; i++) write_stop(i, '0);
    queue_pos(17'd100);
    queue_pos(17'h1FFFF);
    drain();
    // one valid stop; high bits set; offset above one; ties at equal offsets
    write_stop(3, {14'h3FFF, 1'b1, 17'h1FFFF, 32'h1234_5678});
    queue_pos(17'd0);
    queue_pos(17'd65536);
    drain();
    write_stop(5, {14'h0, 1'b1, 17'd32768, 32'h00FF_00FF});
    drain();
    write_stop(6, {14'h0, 1'b1, 17'd32768, 32'hFF00_FF00});
    write_stop(0, {14'h0, 1'b1, 17'd0, 32'hFFFF_FFFF});
    write_stop(1, {14'h0, 1'b1, 17'd0, 32'h0000_0000});
    queue_pos(17'd0);
    queue_pos(17'd1);
    queue_pos(17'd16384);
    queue_pos(17'd32767);
    queue_pos(17'd32768);
    queue_pos(17'd32769);
    queue_pos(17'd65535);
    drain();

    // random phases under three idling profiles
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin send_idle_pct = 9; recv_idle_pct = 74; end
      else if (ph < 8) begin send_idle_pct = 74; recv_idle_pct = 9; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
      random_setting();
      if (ph == 9) hold_req = !hold_req;   // receiver holds off; the block must back up
      for (int i = 0; i < 160; i++) queue_pos(rand_pos());
      if (ph == 5) begin
        // sender pause until everything has come back, then more words
        wait (pos_queue.size() == 0 && colour_queue.size() == 0);
        for (int i = 0; i < 20; i++) queue_pos(rand_pos());
      end
      drain();
    end

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ color_ramp_sampler_top.f @@
rtl/crs_pkg.sv
rtl/color_ramp_sampler_top.sv
tb/tb_color_ramp_sampler_top.sv
